// File: rtl/core/scmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmd_pkg
// Shared constants, codes, state type and a saturation helper of the swarm centroid
// motion decider.
// ----------------------------------------------------------------------------
package scmd_pkg;

    localparam int NUM_ROBOTS = 8;
    localparam int POS_W      = 16;
    localparam int DIST_W     = 16;
    localparam int ID_W       = $clog2(NUM_ROBOTS);
    localparam int CNT_W      = $clog2(NUM_ROBOTS + 1);
    localparam int SUM_W      = POS_W + $clog2(NUM_ROBOTS);
    localparam int TGT_W      = SUM_W + 3;
    localparam int IDX_W      = $clog2(NUM_ROBOTS + 3);
    localparam int SQ_W       = 2 * DIST_W;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_DECIDE = 1'b1;

    localparam logic MODE_AGGREGATE = 1'b0;
    localparam logic MODE_DISPERSE  = 1'b1;

    localparam logic [1:0] CMD_STOP       = 2'd0;
    localparam logic [1:0] CMD_TURN_LEFT  = 2'd1;
    localparam logic [1:0] CMD_TURN_RIGHT = 2'd2;
    localparam logic [1:0] CMD_GOTO       = 2'd3;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_SENSE   = 3'd1;
    localparam logic [2:0] REG_SPACING = 3'd2;
    localparam logic [2:0] REG_TURN    = 3'd3;
    localparam logic [2:0] REG_STOP    = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_START,
        S_DIV,
        S_OUT
    } t_state;

    function automatic logic signed [POS_W-1:0] sat16(input logic signed [TGT_W-1:0] v);
        logic signed [TGT_W-1:0] hi;
        logic signed [TGT_W-1:0] lo;
        hi = TGT_W'(32767);
        lo = -TGT_W'(32768);
        if (v > hi) begin
            sat16 = 16'sh7FFF;
        end else if (v < lo) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = v[POS_W-1:0];
        end
    endfunction

endpackage

// File: rtl/core/scmd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmd_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module scmd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/scmd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmd_div
// Radix-2 restoring divider for both centroid sums, one quotient bit per
// cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module scmd_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [scmd_pkg::SUM_W-1:0]     i_num_x,
    input  logic signed [scmd_pkg::SUM_W-1:0]     i_num_y,
    input  logic        [scmd_pkg::CNT_W-1:0]     i_den,
    output logic                                  o_done,
    output logic signed [scmd_pkg::SUM_W-1:0]     o_quo_x,
    output logic signed [scmd_pkg::SUM_W-1:0]     o_quo_y
);
    import scmd_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_mag_x;
    logic [SUM_W-1:0]  r_mag_y;
    logic [CNT_W-1:0]  r_rem_x;
    logic [CNT_W-1:0]  r_rem_y;
    logic [CNT_W-1:0]  r_den;
    logic              r_neg_x;
    logic              r_neg_y;

    logic [CNT_W:0]    rem_sh_x;
    logic [CNT_W:0]    rem_sh_y;
    logic              ge_x;
    logic              ge_y;
    logic [CNT_W:0]    n_rem_x;
    logic [CNT_W:0]    n_rem_y;

    always_comb begin
        rem_sh_x = {r_rem_x, r_mag_x[SUM_W-1]};
        rem_sh_y = {r_rem_y, r_mag_y[SUM_W-1]};
        ge_x     = (rem_sh_x >= {1'b0, r_den});
        ge_y     = (rem_sh_y >= {1'b0, r_den});
        n_rem_x  = ge_x ? (rem_sh_x - {1'b0, r_den}) : rem_sh_x;
        n_rem_y  = ge_y ? (rem_sh_y - {1'b0, r_den}) : rem_sh_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag_x <= i_num_x[SUM_W-1] ? SUM_W'(-i_num_x) : SUM_W'(i_num_x);
            r_mag_y <= i_num_y[SUM_W-1] ? SUM_W'(-i_num_y) : SUM_W'(i_num_y);
            r_neg_x <= i_num_x[SUM_W-1];
            r_neg_y <= i_num_y[SUM_W-1];
            r_rem_x <= '0;
            r_rem_y <= '0;
            r_den   <= i_den;
        end else if (r_busy) begin
            r_mag_x <= {r_mag_x[SUM_W-2:0], ge_x};
            r_mag_y <= {r_mag_y[SUM_W-2:0], ge_y};
            r_rem_x <= n_rem_x[CNT_W-1:0];
            r_rem_y <= n_rem_y[CNT_W-1:0];
        end
    end

    assign o_done  = r_done;
    assign o_quo_x = r_neg_x ? $signed(-r_mag_x) : $signed(r_mag_x);
    assign o_quo_y = r_neg_y ? $signed(-r_mag_y) : $signed(r_mag_y);

endmodule

// File: rtl/core/swarm_centroid_motion_decider_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swarm_centroid_motion_decider_core
// Position table in a RAM, neighbour scan pipeline, centroid divider and
// motion decision with a registered result.
// ----------------------------------------------------------------------------
// Update item: written to the table RAM, no result.
// Decide item: a scan of every table entry through the RAM read port,
//   then the divider and the control states, result registered at the end;
//   one item in flight at a time.
// Reset: control and configuration registers to their defaults, every table
//   entry reads as zero until written (per-entry valid bits, no clearing pass).
// ----------------------------------------------------------------------------
module swarm_centroid_motion_decider_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_operation,
    input  logic        [2:0]                    i_robot_id,
    input  logic signed [scmd_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [scmd_pkg::POS_W-1:0]    i_pos_y,
    input  logic        [scmd_pkg::DIST_W-1:0]   i_right_clearance,
    input  logic        [scmd_pkg::DIST_W-1:0]   i_left_clearance,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic        [1:0]                    o_command,
    output logic signed [scmd_pkg::POS_W-1:0]    o_target_x,
    output logic signed [scmd_pkg::POS_W-1:0]    o_target_y,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic        [scmd_pkg::ADDR_W-1:0]   paddr,
    input  logic        [scmd_pkg::DATA_W-1:0]   pwdata,
    output logic        [scmd_pkg::DATA_W-1:0]   prdata,
    output logic                                 pready
);
    import scmd_pkg::*;

    localparam logic [IDX_W-1:0] SCAN_ISSUE = IDX_W'(NUM_ROBOTS);
    localparam logic [IDX_W-1:0] SCAN_LAST  = IDX_W'(NUM_ROBOTS + 2);

    // configuration
    logic              r_mode;
    logic [DIST_W-1:0] r_sense;
    logic [DIST_W-1:0] r_spacing;
    logic [DIST_W-1:0] r_turn;
    logic [DIST_W-1:0] r_stop;
    logic [SQ_W-1:0]   r_sense2;
    logic [SQ_W-1:0]   r_space2;
    logic              cfg_wr;
    logic [2:0]        cfg_idx;

    // control
    t_state            r_state;
    t_state            n_state;
    logic [IDX_W-1:0]  r_idx;
    logic              in_acc;
    logic              in_range;
    logic              issue;
    logic              div_start;
    logic              div_done;
    logic              out_free;
    logic              out_load;
    logic [NUM_ROBOTS-1:0] r_tbl_vld;

    // item registers
    logic [ID_W-1:0]          r_own_id;
    logic signed [POS_W-1:0]  r_own_x;
    logic signed [POS_W-1:0]  r_own_y;
    logic [DIST_W-1:0]        r_right;
    logic [DIST_W-1:0]        r_left;

    // table RAM
    logic [ID_W-1:0]          wr_addr;
    logic [ID_W-1:0]          rd_addr;
    logic [2*POS_W-1:0]       rd_data;

    // scan pipeline
    logic                     r_p1_vld;
    logic                     r_p1_tv;
    logic                     r_p1_self;
    logic                     r_p2_vld;
    logic                     r_p2_self;
    logic signed [POS_W:0]    r_p2_dx;
    logic signed [POS_W:0]    r_p2_dy;
    logic signed [POS_W-1:0]  r_p2_x;
    logic signed [POS_W-1:0]  r_p2_y;
    logic                     r_p3_vld;
    logic                     r_p3_self;
    logic [SQ_W-1:0]          r_p3_sqx;
    logic [SQ_W-1:0]          r_p3_sqy;
    logic signed [POS_W-1:0]  r_p3_x;
    logic signed [POS_W-1:0]  r_p3_y;
    logic signed [POS_W-1:0]  p1_x;
    logic signed [POS_W-1:0]  p1_y;
    logic signed [2*POS_W+1:0] sq_x;
    logic signed [2*POS_W+1:0] sq_y;
    logic [SQ_W:0]            d2;
    logic                     in_sense;

    // accumulators
    logic signed [SUM_W-1:0]  r_sum_x;
    logic signed [SUM_W-1:0]  r_sum_y;
    logic [CNT_W-1:0]         r_count;
    logic                     r_all_within;
    logic                     r_other_close;

    // decision
    logic signed [SUM_W-1:0]  cx;
    logic signed [SUM_W-1:0]  cy;
    logic signed [TGT_W-1:0]  cx_e;
    logic signed [TGT_W-1:0]  cy_e;
    logic signed [TGT_W-1:0]  ox_e;
    logic signed [TGT_W-1:0]  oy_e;
    logic [1:0]               dec_cmd;
    logic signed [POS_W-1:0]  dec_tx;
    logic signed [POS_W-1:0]  dec_ty;

    // output register
    logic                     r_out_vld;
    logic [1:0]               r_cmd;
    logic signed [POS_W-1:0]  r_tx;
    logic signed [POS_W-1:0]  r_ty;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_AGGREGATE;
            r_sense   <= DIST_W'(1000);
            r_spacing <= DIST_W'(500);
            r_turn    <= DIST_W'(1000);
            r_stop    <= DIST_W'(650);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MODE:    r_mode    <= pwdata[0];
                REG_SENSE:   r_sense   <= pwdata[DIST_W-1:0];
                REG_SPACING: r_spacing <= pwdata[DIST_W-1:0];
                REG_TURN:    r_turn    <= pwdata[DIST_W-1:0];
                REG_STOP:    r_stop    <= pwdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_MODE:    prdata = {{(DATA_W-1){1'b0}}, r_mode};
            REG_SENSE:   prdata = {{(DATA_W-DIST_W){1'b0}}, r_sense};
            REG_SPACING: prdata = {{(DATA_W-DIST_W){1'b0}}, r_spacing};
            REG_TURN:    prdata = {{(DATA_W-DIST_W){1'b0}}, r_turn};
            REG_STOP:    prdata = {{(DATA_W-DIST_W){1'b0}}, r_stop};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_sense2 <= r_sense * r_sense;
        r_space2 <= r_spacing * r_spacing;
    end

    // ---------------- control ----------------
    assign in_acc   = i_in_valid & ~o_in_stall;
    assign in_range = ({29'd0, i_robot_id} < 32'(NUM_ROBOTS));
    assign out_free = ~r_out_vld | ~i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && in_range && i_operation == OP_DECIDE) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == SCAN_LAST) begin
                    n_state = S_START;
                end
            end
            S_START: n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        issue      = (r_state == S_SCAN) && (r_idx < SCAN_ISSUE);
        div_start  = (r_state == S_START);
        out_load   = (r_state == S_OUT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_tbl_vld <= '0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= (r_state == S_SCAN) ? r_idx + 1'b1 : '0;
            if (in_acc && in_range) begin
                r_tbl_vld[wr_addr] <= 1'b1;
            end
            r_p1_vld <= issue;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (~i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_own_id <= wr_addr;
            r_own_x  <= i_pos_x;
            r_own_y  <= i_pos_y;
            r_right  <= i_right_clearance;
            r_left   <= i_left_clearance;
        end
    end

    // ---------------- table RAM ----------------
    assign wr_addr = ID_W'(i_robot_id);
    assign rd_addr = r_idx[ID_W-1:0];

    scmd_ram #(
        .WIDTH (2 * POS_W),
        .DEPTH (NUM_ROBOTS)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (in_acc & in_range),
        .i_waddr (wr_addr),
        .i_wdata ({i_pos_x, i_pos_y}),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // ---------------- scan pipeline ----------------
    assign p1_x = r_p1_tv ? $signed(rd_data[2*POS_W-1:POS_W]) : '0;
    assign p1_y = r_p1_tv ? $signed(rd_data[POS_W-1:0]) : '0;
    assign sq_x = r_p2_dx * r_p2_dx;
    assign sq_y = r_p2_dy * r_p2_dy;
    assign d2   = {1'b0, r_p3_sqx} + {1'b0, r_p3_sqy};
    assign in_sense = r_p3_vld && (d2 <= {1'b0, r_sense2});

    always_ff @(posedge i_clk) begin
        r_p1_tv   <= r_tbl_vld[rd_addr];
        r_p1_self <= (rd_addr == r_own_id);
        r_p2_self <= r_p1_self;
        r_p2_dx   <= {p1_x[POS_W-1], p1_x} - {r_own_x[POS_W-1], r_own_x};
        r_p2_dy   <= {p1_y[POS_W-1], p1_y} - {r_own_y[POS_W-1], r_own_y};
        r_p2_x    <= p1_x;
        r_p2_y    <= p1_y;
        r_p3_self <= r_p2_self;
        r_p3_sqx  <= sq_x[SQ_W-1:0];
        r_p3_sqy  <= sq_y[SQ_W-1:0];
        r_p3_x    <= r_p2_x;
        r_p3_y    <= r_p2_y;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sum_x       <= '0;
            r_sum_y       <= '0;
            r_count       <= '0;
            r_all_within  <= 1'b1;
            r_other_close <= 1'b0;
        end else if (in_sense) begin
            r_sum_x <= r_sum_x + SUM_W'(r_p3_x);
            r_sum_y <= r_sum_y + SUM_W'(r_p3_y);
            r_count <= r_count + 1'b1;
            if (d2 > {1'b0, r_space2}) begin
                r_all_within <= 1'b0;
            end else if (!r_p3_self) begin
                r_other_close <= 1'b1;
            end
        end
    end

    // ---------------- centroid divider ----------------
    scmd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num_x (r_sum_x),
        .i_num_y (r_sum_y),
        .i_den   (r_count),
        .o_done  (div_done),
        .o_quo_x (cx),
        .o_quo_y (cy)
    );

    // ---------------- decision ----------------
    assign cx_e = TGT_W'(cx);
    assign cy_e = TGT_W'(cy);
    assign ox_e = TGT_W'(r_own_x);
    assign oy_e = TGT_W'(r_own_y);

    always_comb begin
        dec_cmd = CMD_STOP;
        dec_tx  = '0;
        dec_ty  = '0;
        if (r_mode == MODE_AGGREGATE) begin
            if (!r_all_within && r_right >= r_stop && r_left >= r_stop) begin
                dec_cmd = CMD_GOTO;
                dec_tx  = sat16(cx_e);
                dec_ty  = sat16(cy_e);
            end
        end else if (r_other_close) begin
            if (r_right < r_turn || r_left < r_turn) begin
                dec_cmd = (r_right < r_left) ? CMD_TURN_LEFT : CMD_TURN_RIGHT;
            end else begin
                dec_cmd = CMD_GOTO;
                dec_tx  = sat16((ox_e <<< 1) + ox_e - (cx_e <<< 1));
                dec_ty  = sat16((oy_e <<< 1) + oy_e - (cy_e <<< 1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_cmd <= dec_cmd;
            r_tx  <= dec_tx;
            r_ty  <= dec_ty;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_command   = r_cmd;
    assign o_target_x  = r_tx;
    assign o_target_y  = r_ty;

    // ---------------- assertions ----------------
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_self_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> r_count != '0)
        else $error("centroid division started with no neighbour counted");

    a_self_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_tbl_vld[r_own_id])
        else $error("scan started before own position was stored");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_out_valid)
        else $error("decision result lost at the output register");

endmodule
